// ===== sv/bod_pkg.sv =====
`timescale 1ns / 1ps
package bod_pkg;

    localparam int PIXEL_W     = 8;
    localparam int CFG_ORDER_W = 3;
    localparam int CFG_WIDTH_W = 13;
    localparam int CFG_DATA_W  = CFG_WIDTH_W;
    localparam int CFG_IDX_W   = 1;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_ORDER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH   = 1'b1;

    localparam logic [CFG_ORDER_W-1:0] ORDER_RESET = 3'd3;
    localparam logic [CFG_WIDTH_W-1:0] WIDTH_RESET = 13'd1280;

    localparam logic [PIXEL_W-1:0] PIXEL_BLACK = 8'd0;
    localparam logic [PIXEL_W-1:0] PIXEL_WHITE = 8'd255;

    // quadrant code of one recursion level: tl 1, tr 2, bl 3, br 0
    function automatic logic [1:0] quadrant_code(input logic row_bit, input logic col_bit);
        logic [1:0] q;
        unique case ({row_bit, col_bit})
            2'b00:   q = 2'd1;
            2'b01:   q = 2'd2;
            2'b10:   q = 2'd3;
            default: q = 2'd0;
        endcase
        return q;
    endfunction

endpackage

// ===== sv/bayer_ordered_dither_unit.sv =====
`timescale 1ns / 1ps
// channel   direction  handshake          payload
// pixels    in         push / full        i_pixel_in, i_frame_start
// results   out        pop / empty        o_pixel_out
// config    in         i_cfg_we           i_cfg_idx, i_cfg_data
//
// one item per cycle unless full; an item passes the queue, then the output register
// the position counters and index logic sit in front of a four-entry queue,
// the threshold compare and output register behind it
// reset (synchronous, active low) clears position, queue and output valid, and
// loads order 3 and line width 1280
// a withheld pop stalls the output register; the queue absorbs the front until full
module bayer_ordered_dither_unit
    import bod_pkg::*;
#(
    parameter int MAX_LINE_WIDTH = 4096,
    parameter int MAX_ORDER      = 5
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  push,
    output logic                  full,
    input  logic [PIXEL_W-1:0]    i_pixel_in,
    input  logic                  i_frame_start,
    output logic                  empty,
    input  logic                  pop,
    output logic [PIXEL_W-1:0]    o_pixel_out
);

    localparam int OW         = $clog2(MAX_ORDER + 1);
    localparam int IW         = 2 * MAX_ORDER;
    localparam int QW         = PIXEL_W + IW + OW;
    localparam int QUEUE_DEPTH = 4;

    // front side
    logic               front_wr;
    logic [PIXEL_W-1:0] front_pixel;
    logic [IW-1:0]      front_index;
    logic [OW-1:0]      front_order;

    // queue side
    logic [QW-1:0]      q_wr_data, q_rd_data;
    logic               q_empty;
    logic               back_take;

    bod_front #(
        .MAX_LINE_WIDTH (MAX_LINE_WIDTH),
        .MAX_ORDER      (MAX_ORDER),
        .OW             (OW),
        .IW             (IW)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_push        (push),
        .i_full        (full),
        .i_pixel_in    (i_pixel_in),
        .i_frame_start (i_frame_start),
        .o_wr          (front_wr),
        .o_pixel       (front_pixel),
        .o_index       (front_index),
        .o_order       (front_order)
    );

    assign q_wr_data = {front_pixel, front_index, front_order};

    bod_fifo #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_wr),
        .i_data  (q_wr_data),
        .o_full  (full),
        .i_pop   (back_take),
        .o_data  (q_rd_data),
        .o_empty (q_empty)
    );

    bod_back #(
        .MAX_ORDER (MAX_ORDER),
        .OW        (OW),
        .IW        (IW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (!q_empty),
        .i_pixel     (q_rd_data[QW-1 -: PIXEL_W]),
        .i_index     (q_rd_data[OW +: IW]),
        .i_order     (q_rd_data[OW-1:0]),
        .o_take      (back_take),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_pixel_out (o_pixel_out)
    );

endmodule

// ===== sv/bod_fifo.sv =====
`timescale 1ns / 1ps
module bod_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [AW:0]      r_count,  n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == (AW+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== sv/bod_front.sv =====
`timescale 1ns / 1ps
module bod_front
    import bod_pkg::*;
#(
    parameter int MAX_LINE_WIDTH = 4096,
    parameter int MAX_ORDER      = 5,
    parameter int OW             = $clog2(MAX_ORDER + 1),
    parameter int IW             = 2 * MAX_ORDER
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_push,
    input  logic                   i_full,
    input  logic [PIXEL_W-1:0]     i_pixel_in,
    input  logic                   i_frame_start,
    output logic                   o_wr,
    output logic [PIXEL_W-1:0]     o_pixel,
    output logic [IW-1:0]          o_index,
    output logic [OW-1:0]          o_order
);

    localparam int CW = $clog2(MAX_LINE_WIDTH);
    localparam int WW = CW + 1;
    localparam int RW = MAX_ORDER;
    localparam int XW = (CW > MAX_ORDER) ? CW : MAX_ORDER;

    logic [CFG_ORDER_W-1:0] r_cfg_order;
    logic [CFG_WIDTH_W-1:0] r_cfg_width;
    logic [CW-1:0]          r_col, n_col;
    logic [RW-1:0]          r_row, n_row;

    logic [OW-1:0]          eff_order;
    logic [WW-1:0]          eff_width;
    logic [CW-1:0]          cur_col;
    logic [RW-1:0]          cur_row;
    logic [XW-1:0]          col_x;
    logic [IW-1:0]          idx_full;
    logic [OW:0]            drop_levels;
    logic                   accept;

    assign accept = i_push && !i_full;

    // clamp the registers to their meaningful ranges
    always_comb begin
        if (r_cfg_order == '0) begin
            eff_order = OW'(1);
        end else if (32'(r_cfg_order) > MAX_ORDER) begin
            eff_order = OW'(MAX_ORDER);
        end else begin
            eff_order = OW'(r_cfg_order);
        end
        if (r_cfg_width == '0) begin
            eff_width = WW'(1);
        end else if (32'(r_cfg_width) > MAX_LINE_WIDTH) begin
            eff_width = WW'(MAX_LINE_WIDTH);
        end else begin
            eff_width = WW'(r_cfg_width);
        end
    end

    assign cur_col = i_frame_start ? '0 : r_col;
    assign cur_row = i_frame_start ? '0 : r_row;
    assign col_x   = XW'(cur_col);

    // full-depth index, then drop the levels beyond the configured order
    always_comb begin
        idx_full = '0;
        for (int b = 0; b < MAX_ORDER; b++) begin
            idx_full[2*(MAX_ORDER-1-b) +: 2] = quadrant_code(cur_row[b], col_x[b]);
        end
    end

    assign drop_levels = (OW+1)'(MAX_ORDER) - (OW+1)'(eff_order);

    assign o_wr    = accept;
    assign o_pixel = i_pixel_in;
    assign o_index = idx_full >> {drop_levels, 1'b0};
    assign o_order = eff_order;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if ((WW'(cur_col) + 1'b1) >= eff_width) begin
                n_col = '0;
                n_row = cur_row + 1'b1;
            end else begin
                n_col = cur_col + 1'b1;
                n_row = cur_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_order <= ORDER_RESET;
            r_cfg_width <= WIDTH_RESET;
            r_col       <= '0;
            r_row       <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MATRIX_ORDER: r_cfg_order <= i_cfg_data[CFG_ORDER_W-1:0];
                    CFG_LINE_WIDTH:   r_cfg_width <= i_cfg_data[CFG_WIDTH_W-1:0];
                    default:          ;
                endcase
            end
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

// ===== sv/bod_back.sv =====
`timescale 1ns / 1ps
module bod_back
    import bod_pkg::*;
#(
    parameter int MAX_ORDER = 5,
    parameter int OW        = $clog2(MAX_ORDER + 1),
    parameter int IW        = 2 * MAX_ORDER
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [PIXEL_W-1:0] i_pixel,
    input  logic [IW-1:0]      i_index,
    input  logic [OW-1:0]      i_order,
    output logic               o_take,
    input  logic               i_pop,
    output logic               o_empty,
    output logic [PIXEL_W-1:0] o_pixel_out
);

    localparam int LW = PIXEL_W + IW + 1;

    logic               r_valid, n_valid;
    logic [PIXEL_W-1:0] r_pixel;
    logic [LW-1:0]      lhs, rhs, odd_x;
    logic               black;

    // 2*f*n^2 against (2*idx+1)*255
    assign lhs   = LW'(i_pixel) << {i_order, 1'b1};
    assign odd_x = LW'({i_index, 1'b1});
    assign rhs   = (odd_x << PIXEL_W) - odd_x;
    assign black = (lhs <= rhs);

    assign o_take      = i_valid && (!r_valid || i_pop);
    assign o_empty     = !r_valid;
    assign o_pixel_out = r_pixel;

    always_comb begin
        n_valid = r_valid;
        if (o_take) begin
            n_valid = 1'b1;
        end else if (i_pop) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_pixel <= black ? PIXEL_BLACK : PIXEL_WHITE;
        end
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;
    import bod_pkg::*;

    localparam int MAX_LINE_W  = 4096;
    localparam int MAX_ORD     = 5;
    localparam int RAND_PHASES = 10;
    localparam int PHASE_ITEMS = 40;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 200000;

    // one pending input item
    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               sof;
    } t_pixel_item;

    // block ports, all inputs known from time zero
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx     = CFG_MATRIX_ORDER;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  push          = 1'b0;
    logic                  full;
    logic [PIXEL_W-1:0]    i_pixel_in    = '0;
    logic                  i_frame_start = 1'b0;
    logic                  empty;
    logic                  pop           = 1'b0;
    logic [PIXEL_W-1:0]    o_pixel_out;

    bayer_ordered_dither_unit #(
        .MAX_LINE_WIDTH(MAX_LINE_W),
        .MAX_ORDER     (MAX_ORD)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .push         (push),
        .full         (full),
        .i_pixel_in   (i_pixel_in),
        .i_frame_start(i_frame_start),
        .empty        (empty),
        .pop          (pop),
        .o_pixel_out  (o_pixel_out)
    );

    // shadow copy of the registers and of the raster position
    logic [CFG_ORDER_W-1:0] cfg_order = ORDER_RESET;
    logic [CFG_WIDTH_W-1:0] cfg_width = WIDTH_RESET;
    logic [11:0]            col_pos   = '0;
    logic [4:0]             row_pos   = '0;

    t_pixel_item        pending_pixels[$];
    logic [PIXEL_W-1:0] expected_pixels[$];

    int unsigned tx_gap      = 0;
    int unsigned rx_gap      = 0;
    logic        quiet_phase = 1'b0;   // no idling on either side
    logic        hold_go     = 1'b0;   // starts the long receiver hold-off
    logic        rx_hold     = 1'b0;
    int unsigned mismatches  = 0;
    int unsigned cycle_count = 0;

    // halftone value of the next pixel; advances the raster position
    function automatic logic [PIXEL_W-1:0] halftone_predict(input t_pixel_item it);
        int unsigned ord, wid, idx, lhs, rhs;
        logic        r, c;
        ord = cfg_order;
        wid = cfg_width;
        // out-of-range settings clamp to the nearest legal one
        if (ord < 1) ord = 1;
        if (ord > MAX_ORD) ord = MAX_ORD;
        if (wid < 1) wid = 1;
        if (wid > MAX_LINE_W) wid = MAX_LINE_W;
        if (it.sof) begin
            col_pos = '0;
            row_pos = '0;
        end
        // lowest coordinate bit ends up in the highest index bits
        idx = 0;
        for (int b = 0; b < ord; b++) begin
            r   = row_pos[b];
            c   = col_pos[b];
            idx = (idx << 2) + (r ? (c ? 0 : 3) : (c ? 2 : 1));
        end
        lhs = (32'(it.pixel) * 2) << (2 * ord);
        rhs = (2 * idx + 1) * 255;
        // wrap also covers a column left beyond a width that has shrunk
        if (32'(col_pos) + 1 >= wid) begin
            col_pos = '0;
            row_pos = row_pos + 5'd1;
        end else begin
            col_pos = col_pos + 12'd1;
        end
        return (lhs <= rhs) ? PIXEL_BLACK : PIXEL_WHITE;
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int unsigned idle_gap();
        int unsigned r;
        if (quiet_phase) return 0;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(3, 1);
        if (r < 97) return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // sender: offers the oldest pending item, holds it while full is high
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                expected_pixels.push_back(halftone_predict(pending_pixels[0]));
                pending_pixels.delete(0);
            end
            if (!(push && full)) begin
                if (tx_gap != 0) begin
                    tx_gap <= tx_gap - 1;
                    push   <= 1'b0;
                end else if (pending_pixels.size() != 0) begin
                    push          <= 1'b1;
                    i_pixel_in    <= pending_pixels[0].pixel;
                    i_frame_start <= pending_pixels[0].sof;
                    tx_gap        <= idle_gap();
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // receiver: checks each result against the oldest expectation
    always @(posedge i_clk) begin : result_side
        int unsigned gap;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (expected_pixels.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %0d",
                             $time, o_pixel_out);
                    mismatches++;
                end else begin
                    if (o_pixel_out !== expected_pixels[0]) begin
                        $display("%0t: pixel_out mismatch, expected %0d, actual %0d",
                                 $time, expected_pixels[0], o_pixel_out);
                        mismatches++;
                    end
                    expected_pixels.delete(0);
                end
            end
            if (rx_hold) begin
                pop <= 1'b0;
            end else if (pop && !empty) begin
                gap    = idle_gap();
                rx_gap <= gap;
                pop    <= (gap == 0);
            end else if (rx_gap != 0) begin
                rx_gap <= rx_gap - 1;
                pop    <= (rx_gap == 1);
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // long hold-off on the result side so the block backs up and raises full
    initial begin
        wait (hold_go);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    // run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
        $display("** bayer_ordered_dither_unit: FAILED **");
        $finish;
    end

    task automatic send(input logic [PIXEL_W-1:0] pixel, input logic sof);
        t_pixel_item it;
        it.pixel = pixel;
        it.sof   = sof;
        pending_pixels.push_back(it);
    endtask

    // all items taken, all results back, pipeline settled
    task automatic wait_drained();
        while (pending_pixels.size() != 0 || push || expected_pixels.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // writes the order register, then the line width register; unused order bits carry noise
    task automatic set_config(input int unsigned order, input int unsigned width);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_MATRIX_ORDER;
        i_cfg_data <= {(CFG_DATA_W-CFG_ORDER_W)'($urandom), CFG_ORDER_W'(order)};
        @(posedge i_clk);
        i_cfg_idx  <= CFG_LINE_WIDTH;
        i_cfg_data <= CFG_DATA_W'(width);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cfg_order  = CFG_ORDER_W'(order);
        cfg_width  = CFG_WIDTH_W'(width);
        @(negedge i_clk);
    endtask

    // a run of random pixels; sof_odds gives one frame start in that many, 0 for none
    task automatic random_phase(input int unsigned n, input logic sof_first,
                                input int unsigned sof_odds);
        t_pixel_item it;
        int unsigned r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            if (r < 5)
                it.pixel = '0;
            else if (r < 10)
                it.pixel = '1;
            else
                it.pixel = PIXEL_W'($urandom);
            if (k == 0)
                it.sof = sof_first;
            else
                it.sof = (sof_odds != 0) && ($urandom_range(sof_odds - 1) == 0);
            pending_pixels.push_back(it);
        end
    endtask

    // stimulus
    initial begin
        int unsigned r, wid;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings, pixel extremes and values around mid grey
        send(8'd0, 1'b1);
        send(8'd255, 1'b0);
        send(8'd1, 1'b0);
        send(8'd254, 1'b0);
        send(8'd127, 1'b0);
        send(8'd128, 1'b0);
        send(8'd64, 1'b1);
        send(8'd192, 1'b0);
        wait_drained();

        // order zero and width zero both behave as one
        set_config(0, 0);
        send(8'd64, 1'b0);
        send(8'd191, 1'b0);
        send(8'd192, 1'b0);
        send(8'd255, 1'b0);
        wait_drained();

        // order and width above range clamp to the maximum
        set_config(7, 8191);
        send(8'h55, 1'b0);
        send(8'haa, 1'b0);
        send(8'hf0, 1'b1);
        send(8'h0f, 1'b0);
        wait_drained();

        // width shrunk while the column sits beyond it
        set_config(1, 40);
        for (int k = 0; k < 6; k++) send(8'd100, 1'b0);
        wait_drained();
        set_config(1, 3);
        send(8'd60, 1'b0);
        send(8'd200, 1'b0);
        send(8'd130, 1'b0);
        wait_drained();

        // random settings, mostly short lines so rows advance quickly
        for (int p = 0; p < RAND_PHASES; p++) begin
            r = $urandom_range(99);
            if (r < 70)
                wid = $urandom_range(70, 1);
            else if (r < 80)
                wid = 0;
            else if (r < 90)
                wid = $urandom_range(8191, 4096);
            else
                wid = $urandom_range(4095, 71);
            set_config($urandom_range(7), wid);
            quiet_phase = (p % 4 == 3);
            if (p == 2) begin
                // sender keeps offering while the receiver holds off
                quiet_phase = 1'b1;
                hold_go     = 1'b1;
            end
            random_phase(PHASE_ITEMS, 1'($urandom_range(1)), 50);
            wait_drained();
        end

        repeat (8) @(negedge i_clk);
        if (mismatches == 0)
            $display("** bayer_ordered_dither_unit: PASSED **");
        else
            $display("** bayer_ordered_dither_unit: FAILED **");
        $finish;
    end

endmodule

// ===== bayer_ordered_dither_unit.f =====
sv/bod_pkg.sv
sv/bod_fifo.sv
sv/bod_front.sv
sv/bod_back.sv
sv/bayer_ordered_dither_unit.sv
tb/tb.sv
